// ----- src/ups_pkg.sv -----
// Shared types and constants for the pixel replication upscaler.
package ups_pkg;

   localparam int PIXEL_W     = 24;
   localparam int IN_WIDTH_W  = 11;
   localparam int IN_HEIGHT_W = 16;
   localparam int SCALE_W     = 7;
   localparam int PAD_W       = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IN_WIDTH  = 2'd0,
      REG_IN_HEIGHT = 2'd1,
      REG_SCALE     = 2'd2,
      REG_UNUSED    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_STORED   = 2'd0,
      STATUS_VALID    = 2'd1,
      STATUS_NONE     = 2'd2,
      STATUS_REJECTED = 2'd3
   } status_type;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_PULL  = 1'b1
   } kind_type;

   typedef struct packed {
      status_type status;
      logic       is_pad;
      logic       row_end;
      logic       frame_end;
      logic       use_mem;
   } rsp_ctrl_type;

endpackage

// ----- src/ups_line_ram.sv -----
// Line store: single-port-write, registered-read memory for one input row.
module ups_line_ram import ups_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [PIXEL_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [PIXEL_W-1:0] rd_data_ff
);

   logic [PIXEL_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- src/ups_seq.sv -----
// Sequencer: configuration registers, row and replay counters, line store addressing.
module ups_seq import ups_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_SCALE = 100,
   parameter int AW        = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   fire,
   input  logic                   kind,
   output logic                   mem_wr_en,
   output logic [AW-1:0]          mem_wr_addr,
   output logic                   mem_rd_en,
   output logic [AW-1:0]          mem_rd_addr,
   output rsp_ctrl_type           rsp_ctrl
);

   logic [IN_WIDTH_W-1:0]  eff_width_ff,  eff_width_in;
   logic [IN_HEIGHT_W-1:0] eff_height_ff, eff_height_in;
   logic [SCALE_W-1:0]     eff_scale_ff,  eff_scale_in;

   logic [IN_WIDTH_W-1:0]  in_column_ff,  in_column_in;
   logic [IN_HEIGHT_W-1:0] in_row_ff,     in_row_in;
   logic                   row_ready_ff,  row_ready_in;
   logic [SCALE_W-1:0]     out_copy_ff,   out_copy_in;
   logic [IN_WIDTH_W-1:0]  out_column_ff, out_column_in;
   logic [SCALE_W-1:0]     out_repeat_ff, out_repeat_in;
   logic [PAD_W-1:0]       out_pad_ff,    out_pad_in;

   logic [PAD_W-1:0]      pad;
   logic [2*PAD_W-1:0]    pad_prod;
   logic [IN_WIDTH_W:0]   in_col_next;
   logic [IN_WIDTH_W:0]   out_col_next;
   logic [SCALE_W:0]      copy_next;
   logic [SCALE_W:0]      repeat_next;
   logic [PAD_W:0]        pad_next;
   logic [IN_HEIGHT_W:0]  row_next;
   logic                  row_end;
   logic                  restart;
   logic [IN_WIDTH_W-1:0] wdata_width;
   logic [SCALE_W-1:0]    wdata_scale;

   // The pad byte count equals (width * scale) mod 4, since 3 is -1 modulo 4.
   assign pad_prod = eff_width_ff[PAD_W-1:0] * eff_scale_ff[PAD_W-1:0];
   assign pad      = pad_prod[PAD_W-1:0];

   always_comb begin
      wdata_width = csr_wdata[IN_WIDTH_W-1:0];
      if (wdata_width == '0) begin
         wdata_width = IN_WIDTH_W'(1);
      end else if (32'(wdata_width) > MAX_WIDTH) begin
         wdata_width = IN_WIDTH_W'(MAX_WIDTH);
      end
      wdata_scale = csr_wdata[SCALE_W-1:0];
      if (wdata_scale == '0) begin
         wdata_scale = SCALE_W'(1);
      end else if (32'(wdata_scale) > MAX_SCALE) begin
         wdata_scale = SCALE_W'(MAX_SCALE);
      end
   end

   always_comb begin
      eff_width_in  = eff_width_ff;
      eff_height_in = eff_height_ff;
      eff_scale_in  = eff_scale_ff;
      restart       = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            REG_IN_WIDTH: begin
               eff_width_in = wdata_width;
               restart      = 1'b1;
            end
            REG_IN_HEIGHT: begin
               eff_height_in = (csr_wdata == '0) ? IN_HEIGHT_W'(1) : csr_wdata;
               restart       = 1'b1;
            end
            REG_SCALE: begin
               eff_scale_in = wdata_scale;
               restart      = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      in_column_in  = in_column_ff;
      in_row_in     = in_row_ff;
      row_ready_in  = row_ready_ff;
      out_copy_in   = out_copy_ff;
      out_column_in = out_column_ff;
      out_repeat_in = out_repeat_ff;
      out_pad_in    = out_pad_ff;

      in_col_next  = {1'b0, in_column_ff} + 1'b1;
      out_col_next = {1'b0, out_column_ff} + 1'b1;
      copy_next    = {1'b0, out_copy_ff} + 1'b1;
      repeat_next  = {1'b0, out_repeat_ff} + 1'b1;
      pad_next     = {1'b0, out_pad_ff} + 1'b1;
      row_next     = {1'b0, in_row_ff} + 1'b1;

      row_end   = 1'b0;
      mem_wr_en = 1'b0;
      mem_rd_en = 1'b0;
      rsp_ctrl  = '{status: STATUS_NONE, is_pad: 1'b0, row_end: 1'b0,
                    frame_end: 1'b0, use_mem: 1'b0};

      if (fire) begin
         if (kind == KIND_PIXEL) begin
            if (row_ready_ff) begin
               rsp_ctrl.status = STATUS_REJECTED;
            end else begin
               rsp_ctrl.status = STATUS_STORED;
               mem_wr_en       = 1'b1;
               in_column_in    = in_col_next[IN_WIDTH_W-1:0];
               if (in_col_next >= {1'b0, eff_width_ff}) begin
                  in_column_in  = '0;
                  row_ready_in  = 1'b1;
                  out_copy_in   = '0;
                  out_column_in = '0;
                  out_repeat_in = '0;
                  out_pad_in    = '0;
               end
            end
         end else if (row_ready_ff) begin
            rsp_ctrl.status = STATUS_VALID;
            if (out_column_ff < eff_width_ff) begin
               mem_rd_en        = 1'b1;
               rsp_ctrl.use_mem = 1'b1;
               out_copy_in      = copy_next[SCALE_W-1:0];
               if (copy_next >= {1'b0, eff_scale_ff}) begin
                  out_copy_in   = '0;
                  out_column_in = out_col_next[IN_WIDTH_W-1:0];
                  row_end = (out_col_next >= {1'b0, eff_width_ff}) && (pad == '0);
               end
            end else begin
               rsp_ctrl.is_pad = 1'b1;
               out_pad_in      = pad_next[PAD_W-1:0];
               row_end         = pad_next >= {1'b0, pad};
            end
            if (row_end) begin
               out_column_in = '0;
               out_copy_in   = '0;
               out_pad_in    = '0;
               out_repeat_in = repeat_next[SCALE_W-1:0];
               if (repeat_next >= {1'b0, eff_scale_ff}) begin
                  out_repeat_in = '0;
                  row_ready_in  = 1'b0;
                  in_row_in     = row_next[IN_HEIGHT_W-1:0];
                  if (row_next >= {1'b0, eff_height_ff}) begin
                     in_row_in          = '0;
                     rsp_ctrl.frame_end = 1'b1;
                  end
               end
            end
            rsp_ctrl.row_end = row_end;
         end
      end

      // Users must write configuration only while the block is idle; it is not enforced, so a write simply wins.
      if (restart) begin
         in_column_in  = '0;
         in_row_in     = '0;
         row_ready_in  = 1'b0;
         out_copy_in   = '0;
         out_column_in = '0;
         out_repeat_in = '0;
         out_pad_in    = '0;
      end
   end

   // A read is only issued after the whole row was written in earlier cycles.
   assign mem_wr_addr = AW'(in_column_ff);
   assign mem_rd_addr = AW'(out_column_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_width_ff  <= IN_WIDTH_W'(1);
         eff_height_ff <= IN_HEIGHT_W'(1);
         eff_scale_ff  <= SCALE_W'(1);
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         row_ready_ff  <= 1'b0;
         out_copy_ff   <= '0;
         out_column_ff <= '0;
         out_repeat_ff <= '0;
         out_pad_ff    <= '0;
      end else begin
         eff_width_ff  <= eff_width_in;
         eff_height_ff <= eff_height_in;
         eff_scale_ff  <= eff_scale_in;
         in_column_ff  <= in_column_in;
         in_row_ff     <= in_row_in;
         row_ready_ff  <= row_ready_in;
         out_copy_ff   <= out_copy_in;
         out_column_ff <= out_column_in;
         out_repeat_ff <= out_repeat_in;
         out_pad_ff    <= out_pad_in;
      end
   end

endmodule

// ----- src/integer_pixel_replication_upscaler.sv -----
// Top level of the integer pixel replication upscaler.
//
//   Channel  Ports                       Beat
//   request  req_valid / req_ready       kind, pixel
//   response rsp_valid / rsp_ready       status, value, is_pad, row_end, frame_end
//   csr      csr_wr_en                   csr_index, csr_wdata (no wait, no read-back)
//
// Each accepted request beat gives one registered response beat; one beat per cycle is
// sustained without a stall, limited by the single line store read port and the output
// register. Reset is synchronous; it clears all counters and sets every csr register to
// 1. The line store is not cleared. A stalled response holds the output register and the
// line store read data, and a new request is taken in the cycle the held beat leaves.
module integer_pixel_replication_upscaler import ups_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_SCALE = 100
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   input  logic [PIXEL_W-1:0]     req_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [PIXEL_W-1:0]     rsp_value,
   output logic                   rsp_is_pad,
   output logic                   rsp_row_end,
   output logic                   rsp_frame_end,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic               fire;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_rd_addr;
   logic [PIXEL_W-1:0] mem_rd_data;
   rsp_ctrl_type       rsp_ctrl;
   rsp_ctrl_type       out_ctrl_ff, out_ctrl_in;
   logic               out_valid_ff, out_valid_in;

   assign req_ready = !out_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   ups_seq #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE),
      .AW        (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fire        (fire),
      .kind        (req_kind),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .rsp_ctrl    (rsp_ctrl)
   );

   ups_line_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_line_ram (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (req_pixel),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_ctrl_in  = out_ctrl_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         out_ctrl_in  = rsp_ctrl;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ctrl_ff <= out_ctrl_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_ctrl_ff.status;
   assign rsp_value     = out_ctrl_ff.use_mem ? mem_rd_data : '0;
   assign rsp_is_pad    = out_ctrl_ff.is_pad;
   assign rsp_row_end   = out_ctrl_ff.row_end;
   assign rsp_frame_end = out_ctrl_ff.frame_end;

endmodule
